// File: rtl/wbft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbft_pkg
// Shared types and constants of the world-to-body frame transform core.
// ----------------------------------------------------------------------------
package wbft_pkg;

  localparam int ANG_W  = 20;
  localparam int RED_W  = 22;
  localparam int XY_W   = 34;
  localparam int Z_W    = 32;
  localparam int SC_W   = 21;
  localparam int PR_W   = 2 * SC_W;
  localparam int Q54_W  = 64;
  localparam int ROW_W  = 34;
  localparam int ITERS  = 20;

  localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [35:0]      MRAD        = 36'sd4912665101;
  localparam logic signed [RED_W-1:0] TURN        = 22'sd360000;
  localparam logic signed [RED_W-1:0] HALF_TURN   = 22'sd180000;
  localparam logic signed [RED_W-1:0] QUARTER_TURN = 22'sd90000;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  function automatic logic signed [Z_W-1:0] atan_q28(input int unsigned idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/world_to_body_frame_transform_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// world_to_body_frame_transform_core
// World point to sensor body frame: offset, three CORDIC angle lanes in a
// chain of rotation cells, matrix build, dot products with saturation.
//
//   channel  valid      stall      words
//   input    in_valid   in_stall   in_point_*, in_position_*, in_*_angle
//   output   out_valid  out_stall  out_x, out_y, out_z
//
// One word per cycle sustained while out_stall is low; stages are prep,
// 20 CORDIC cells, two matrix stages, three dot product stages.
// Reset clears only the stage valid flags.
// Each stage holds while it is full and the stage after it holds; empty
// stages still fill, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module world_to_body_frame_transform_core #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_position_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_position_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_position_z,
  input  wire logic signed [19:0]            in_roll_angle,
  input  wire logic signed [19:0]            in_pitch_angle,
  input  wire logic signed [19:0]            in_yaw_angle,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [COORD_WIDTH-1:0]      out_z
);
  import wbft_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int NST = ITERS + 6;

  logic [NST-1:0] v_r, v_nxt;
  logic [NST:0]   rdy;

  lanes_t              lane [ITERS+1];
  logic [3*DW-1:0]     dv [ITERS+1];
  logic [3*ROW_W-1:0]  r0, r1, r2;
  logic [3*DW-1:0]     dm;

  always_comb begin
    rdy[NST] = ~out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = ~v_r[i] | rdy[i+1];
    end
    for (int i = 0; i < NST; i++) begin
      if (rdy[i]) begin
        v_nxt[i] = (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = ~rdy[0];
  assign out_valid = v_r[NST-1];

  wbft_prep #(.CW(COORD_WIDTH)) u_prep (
    .clk         (clk),
    .en          (rdy[0]),
    .point_x     (in_point_x),
    .point_y     (in_point_y),
    .point_z     (in_point_z),
    .position_x  (in_position_x),
    .position_y  (in_position_y),
    .position_z  (in_position_z),
    .roll_angle  (in_roll_angle),
    .pitch_angle (in_pitch_angle),
    .yaw_angle   (in_yaw_angle),
    .lane_r      (lane[0]),
    .d_r         (dv[0])
  );

  for (genvar g = 0; g < ITERS; g++) begin : g_cell
    wbft_cordic_cell #(.CW(COORD_WIDTH), .ITER(g)) u_cell (
      .clk    (clk),
      .en     (rdy[g+1]),
      .lane_i (lane[g]),
      .d_i    (dv[g]),
      .lane_r (lane[g+1]),
      .d_r    (dv[g+1])
    );
  end

  wbft_matrix #(.CW(COORD_WIDTH)) u_matrix (
    .clk    (clk),
    .en     (rdy[ITERS+2:ITERS+1]),
    .lane_i (lane[ITERS]),
    .d_i    (dv[ITERS]),
    .r0_r   (r0),
    .r1_r   (r1),
    .r2_r   (r2),
    .d_r    (dm)
  );

  wbft_dot #(.CW(COORD_WIDTH)) u_dot (
    .clk  (clk),
    .en   (rdy[ITERS+5:ITERS+3]),
    .ra_i (r0),
    .rb_i (r2),
    .rc_i (r1),
    .d_i  (dm),
    .oa_r (out_x),
    .ob_r (out_y),
    .oc_r (out_z)
  );

endmodule
`default_nettype wire

// File: rtl/wbft_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbft_prep
// Offset subtraction, angle reduction and conversion to Q28 radians.
// ----------------------------------------------------------------------------
module wbft_prep #(
  parameter int CW = 32
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [CW-1:0]     point_x,
  input  wire logic signed [CW-1:0]     point_y,
  input  wire logic signed [CW-1:0]     point_z,
  input  wire logic signed [CW-1:0]     position_x,
  input  wire logic signed [CW-1:0]     position_y,
  input  wire logic signed [CW-1:0]     position_z,
  input  wire logic signed [19:0]       roll_angle,
  input  wire logic signed [19:0]       pitch_angle,
  input  wire logic signed [19:0]       yaw_angle,
  output wbft_pkg::lanes_t              lane_r,
  output logic [3*(CW+1)-1:0]           d_r
);
  import wbft_pkg::*;

  function automatic lane_t start_lane(input logic signed [ANG_W-1:0] f);
    logic signed [RED_W-1:0] a;
    logic signed [RED_W-1:0] r;
    logic signed [57:0]      p;
    logic                    fl;
    lane_t                   l;
    a  = RED_W'(0) - RED_W'(f);
    if (a > HALF_TURN) begin
      r = a - TURN;
    end else if (a <= -HALF_TURN) begin
      r = a + TURN;
    end else begin
      r = a;
    end
    fl = 1'b0;
    if (r > QUARTER_TURN) begin
      r  = r - HALF_TURN;
      fl = 1'b1;
    end else if (r < -QUARTER_TURN) begin
      r  = r + HALF_TURN;
      fl = 1'b1;
    end
    p      = 58'(r) * 58'(MRAD);
    p      = p + 58'sd524288;
    l.z    = Z_W'(p >>> 20);
    l.x    = CORDIC_GAIN;
    l.y    = '0;
    l.flip = fl;
    return l;
  endfunction

  lanes_t                lane_nxt;
  logic [3*(CW+1)-1:0]   d_nxt;

  always_comb begin
    lane_nxt[0] = start_lane(roll_angle);
    lane_nxt[1] = start_lane(pitch_angle);
    lane_nxt[2] = start_lane(yaw_angle);
    d_nxt = {(CW+1)'(point_z) - (CW+1)'(position_z),
             (CW+1)'(point_y) - (CW+1)'(position_y),
             (CW+1)'(point_x) - (CW+1)'(position_x)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
      d_r    <= d_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/wbft_cordic_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbft_cordic_cell
// One rotation step of the CORDIC for all three angles; offsets ride along.
// ----------------------------------------------------------------------------
module wbft_cordic_cell #(
  parameter int CW   = 32,
  parameter int ITER = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire wbft_pkg::lanes_t     lane_i,
  input  wire logic [3*(CW+1)-1:0]  d_i,
  output wbft_pkg::lanes_t          lane_r,
  output logic [3*(CW+1)-1:0]       d_r
);
  import wbft_pkg::*;

  lanes_t lane_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lane_nxt[j].flip = lane_i[j].flip;
      if (lane_i[j].z >= 0) begin
        lane_nxt[j].x = lane_i[j].x - (lane_i[j].y >>> ITER);
        lane_nxt[j].y = lane_i[j].y + (lane_i[j].x >>> ITER);
        lane_nxt[j].z = lane_i[j].z - atan_q28(ITER);
      end else begin
        lane_nxt[j].x = lane_i[j].x + (lane_i[j].y >>> ITER);
        lane_nxt[j].y = lane_i[j].y - (lane_i[j].x >>> ITER);
        lane_nxt[j].z = lane_i[j].z + atan_q28(ITER);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
      d_r    <= d_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/wbft_matrix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbft_matrix
// Sine and cosine rounding, then the nine Q30 entries of the rotation.
// ----------------------------------------------------------------------------
module wbft_matrix #(
  parameter int CW = 32
) (
  input  wire logic                        clk,
  input  wire logic [1:0]                  en,
  input  wire wbft_pkg::lanes_t            lane_i,
  input  wire logic [3*(CW+1)-1:0]         d_i,
  output logic [3*wbft_pkg::ROW_W-1:0]     r0_r,
  output logic [3*wbft_pkg::ROW_W-1:0]     r1_r,
  output logic [3*wbft_pkg::ROW_W-1:0]     r2_r,
  output logic [3*(CW+1)-1:0]              d_r
);
  import wbft_pkg::*;

  function automatic logic signed [SC_W-1:0] rnd18(input logic signed [XY_W-1:0] v,
                                                   input logic fl);
    logic signed [XY_W-1:0] t;
    logic signed [SC_W-1:0] q;
    t = (v + XY_W'(2048)) >>> 12;
    q = SC_W'(t);
    return fl ? -q : q;
  endfunction

  function automatic logic signed [ROW_W-1:0] rnd30(input logic signed [Q54_W-1:0] v);
    logic signed [Q54_W-1:0] t;
    t = (v + 64'sd8388608) >>> 24;
    return ROW_W'(t);
  endfunction

  function automatic logic signed [Q54_W-1:0] up18(input logic signed [PR_W-1:0] v);
    logic signed [Q54_W-1:0] t;
    t = Q54_W'(v);
    return t <<< 18;
  endfunction

  function automatic logic signed [Q54_W-1:0] tri3(input logic signed [PR_W-1:0] a,
                                                   input logic signed [SC_W-1:0] b);
    logic signed [Q54_W-1:0] t;
    t = Q54_W'(a) * Q54_W'(b);
    return t;
  endfunction

  logic signed [SC_W-1:0] sy, cy, sx, cx, sz, cz;
  logic signed [PR_W-1:0] cycz_r, sysx_r, cysz_r, sycz_r, sysz_r;
  logic signed [PR_W-1:0] cxsz_r, cxcz_r, sycx_r, cycx_r, cysx_r;
  logic signed [SC_W-1:0] sx_r, sz_r, cz_r;
  logic [3*(CW+1)-1:0]    d_m_r;
  logic signed [Q54_W-1:0] s12;
  logic [3*ROW_W-1:0]     r0_nxt, r1_nxt, r2_nxt;

  always_comb begin
    sy = rnd18(lane_i[0].y, lane_i[0].flip);
    cy = rnd18(lane_i[0].x, lane_i[0].flip);
    sx = rnd18(lane_i[1].y, lane_i[1].flip);
    cx = rnd18(lane_i[1].x, lane_i[1].flip);
    sz = rnd18(lane_i[2].y, lane_i[2].flip);
    cz = rnd18(lane_i[2].x, lane_i[2].flip);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cycz_r <= PR_W'(cy * cz);
      sysx_r <= PR_W'(sy * sx);
      cysz_r <= PR_W'(cy * sz);
      sycz_r <= PR_W'(sy * cz);
      sysz_r <= PR_W'(sy * sz);
      cxsz_r <= PR_W'(cx * sz);
      cxcz_r <= PR_W'(cx * cz);
      sycx_r <= PR_W'(sy * cx);
      cycx_r <= PR_W'(cy * cx);
      cysx_r <= PR_W'(cy * sx);
      sx_r   <= sx;
      sz_r   <= sz;
      cz_r   <= cz;
      d_m_r  <= d_i;
    end
  end

  always_comb begin
    s12 = Q54_W'(sx_r) <<< 36;
    r0_nxt = {rnd30(up18(sycx_r)),
              rnd30(tri3(sysx_r, cz_r) - up18(cysz_r)),
              rnd30(up18(cycz_r) + tri3(sysx_r, sz_r))};
    r1_nxt = {rnd30(-s12),
              rnd30(up18(cxcz_r)),
              rnd30(up18(cxsz_r))};
    r2_nxt = {rnd30(-up18(cycx_r)),
              rnd30(-(up18(sysz_r) + tri3(cysx_r, cz_r))),
              rnd30(up18(sycz_r) - tri3(cysx_r, sz_r))};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r0_r <= r0_nxt;
      r1_r <= r1_nxt;
      r2_r <= r2_nxt;
      d_r  <= d_m_r;
    end
  end

endmodule
`default_nettype wire

// File: rtl/wbft_dot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbft_dot
// Row by offset dot products on split offsets, rounding and saturation.
// ----------------------------------------------------------------------------
module wbft_dot #(
  parameter int CW = 32
) (
  input  wire logic                        clk,
  input  wire logic [2:0]                  en,
  input  wire logic [3*wbft_pkg::ROW_W-1:0] ra_i,
  input  wire logic [3*wbft_pkg::ROW_W-1:0] rb_i,
  input  wire logic [3*wbft_pkg::ROW_W-1:0] rc_i,
  input  wire logic [3*(CW+1)-1:0]         d_i,
  output logic signed [CW-1:0]             oa_r,
  output logic signed [CW-1:0]             ob_r,
  output logic signed [CW-1:0]             oc_r
);
  import wbft_pkg::*;

  localparam int DW   = CW + 1;
  localparam int LO   = DW / 2;
  localparam int HI   = DW - LO;
  localparam int PL_W = ROW_W + LO + 1;
  localparam int PH_W = ROW_W + HI;
  localparam int SL_W = PL_W + 2;
  localparam int SH_W = PH_W + 2;
  localparam int TW   = SH_W + LO + 2;
  localparam logic signed [TW-1:0] SAT_HI = TW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);
  localparam logic signed [TW-1:0] HALF   = TW'(64'sd536870912);

  logic signed [ROW_W-1:0] row [3][3];
  logic signed [PL_W-1:0]  pl_nxt [3][3];
  logic signed [PH_W-1:0]  ph_nxt [3][3];
  logic signed [PL_W-1:0]  pl_r [3][3];
  logic signed [PH_W-1:0]  ph_r [3][3];
  logic signed [SL_W-1:0]  sl_r [3];
  logic signed [SH_W-1:0]  sh_r [3];
  logic signed [CW-1:0]    o_nxt [3];
  logic signed [DW-1:0]    dj;
  logic signed [LO:0]      dl;
  logic signed [HI-1:0]    dh;
  logic signed [TW-1:0]    tot;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      row[0][j] = $signed(ra_i[j*ROW_W +: ROW_W]);
      row[1][j] = $signed(rb_i[j*ROW_W +: ROW_W]);
      row[2][j] = $signed(rc_i[j*ROW_W +: ROW_W]);
    end
    dj = '0;
    dl = '0;
    dh = '0;
    for (int j = 0; j < 3; j++) begin
      dj = $signed(d_i[j*DW +: DW]);
      dl = $signed({1'b0, dj[LO-1:0]});
      dh = HI'(dj >>> LO);
      for (int k = 0; k < 3; k++) begin
        pl_nxt[k][j] = PL_W'(PL_W'(row[k][j]) * PL_W'(dl));
        ph_nxt[k][j] = PH_W'(PH_W'(row[k][j]) * PH_W'(dh));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        sl_r[k] <= SL_W'(pl_r[k][0]) + SL_W'(pl_r[k][1]) + SL_W'(pl_r[k][2]);
        sh_r[k] <= SH_W'(ph_r[k][0]) + SH_W'(ph_r[k][1]) + SH_W'(ph_r[k][2]);
      end
    end
  end

  always_comb begin
    tot = '0;
    for (int k = 0; k < 3; k++) begin
      tot = ((TW'(sh_r[k]) <<< LO) + TW'(sl_r[k]) + HALF) >>> 30;
      if (tot > SAT_HI) begin
        o_nxt[k] = CW'(SAT_HI);
      end else if (tot < SAT_LO) begin
        o_nxt[k] = CW'(SAT_LO);
      end else begin
        o_nxt[k] = CW'(tot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      oa_r <= o_nxt[0];
      ob_r <= o_nxt[1];
      oc_r <= o_nxt[2];
    end
  end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the world-to-body frame transform core against a bit-exact predictor
// of offset, CORDIC trig, matrix build and rounded saturated dot products.
// A directed table of edge words runs first, then bursts of random words with
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CW = 32;
  localparam int LATENCY = 26;
  localparam int N_RANDOM = 1300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ANG_TURN = 360000;
  localparam int ANG_HALF = 180000;
  localparam int ANG_QUARTER = 90000;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint MRAD_Q48 = 64'sd4912665101;

  typedef struct {
    logic signed [CW-1:0] px, py, pz, ox, oy, oz;
    logic signed [19:0]   roll, pitch, yaw;
  } point_word_t;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
  } body_word_t;

  typedef struct {
    point_word_t w;
    bit          known;
    body_word_t  r;
  } table_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [CW-1:0] in_point_x, in_point_y, in_point_z;
  logic signed [CW-1:0] in_position_x, in_position_y, in_position_z;
  logic signed [19:0]   in_roll_angle, in_pitch_angle, in_yaw_angle;
  logic signed [CW-1:0] out_x, out_y, out_z;

  world_to_body_frame_transform_core #(.COORD_WIDTH(CW)) i_dut (.*);

  body_word_t pending_body[$];
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int cycles = 0;
  bit stall_free = 0;
  table_row_t dir_rows[$];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic void neg_angle_trig(logic signed [19:0] field,
                                         output longint s, output longint c);
    longint a, r, z, x, y, xs, ys;
    longint atan_tab[20] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                             8385879, 4193963, 2097109, 1048571, 524287, 262144,
                             131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
                             512};
    bit flip;
    a = -longint'(field);
    flip = 0;
    r = a % ANG_TURN;
    if (r < 0) r += ANG_TURN;
    if (r > ANG_HALF) r -= ANG_TURN;
    if (r > ANG_QUARTER) begin
      r -= ANG_HALF;
      flip = 1;
    end else if (r < -ANG_QUARTER) begin
      r += ANG_HALF;
      flip = 1;
    end
    z = shr_floor(r * MRAD_Q48 + (64'sd1 <<< 19), 20);
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    c = shr_floor(x + 2048, 12);
    s = shr_floor(y + 2048, 12);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic longint to_q30(longint v);
    return shr_floor(v + (64'sd1 <<< 23), 24);
  endfunction

  function automatic longint dot_rounded(longint row[3], longint d[3]);
    longint h, l, dh, dl;
    h = 0;
    l = 0;
    for (int j = 0; j < 3; j++) begin
      dh = shr_floor(d[j], 24);
      dl = d[j] - dh * 64'sd16777216;
      h += row[j] * dh;
      l += row[j] * dl;
    end
    return shr_floor(h + shr_floor(l + (64'sd1 <<< 29), 24), 6);
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function automatic body_word_t transform_point(point_word_t w);
    longint d[3], r0[3], r1[3], r2[3];
    longint sy, cy, sx, cx, sz, cz, u;
    body_word_t b;
    u = 64'sd1 <<< 18;
    d[0] = longint'(w.px) - longint'(w.ox);
    d[1] = longint'(w.py) - longint'(w.oy);
    d[2] = longint'(w.pz) - longint'(w.oz);
    neg_angle_trig(w.roll, sy, cy);
    neg_angle_trig(w.pitch, sx, cx);
    neg_angle_trig(w.yaw, sz, cz);
    r0[0] = to_q30(cy * cz * u + sy * sx * sz);
    r0[1] = to_q30(-cy * sz * u + sy * sx * cz);
    r0[2] = to_q30(sy * cx * u);
    r1[0] = to_q30(cx * sz * u);
    r1[1] = to_q30(cx * cz * u);
    r1[2] = to_q30(-sx * u * u);
    r2[0] = to_q30(-(-sy * cz * u + cy * sx * sz));
    r2[1] = to_q30(-(sy * sz * u + cy * sx * cz));
    r2[2] = to_q30(-(cy * cx * u));
    b.x = clamp_coord(dot_rounded(r0, d));
    b.y = clamp_coord(dot_rounded(r2, d));
    b.z = clamp_coord(dot_rounded(r1, d));
    return b;
  endfunction

  function automatic logic signed [19:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 20'($urandom);
      1: return 20'(int'($urandom_range(0, 8)) * ANG_QUARTER / 2 - 360000);
      default: return 20'(int'($urandom_range(0, 720000)) - 360000);
    endcase
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return CW'($urandom);
      3: return CW'(int'($urandom_range(0, 2000)) - 1000);
      default: return CW'(int'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic point_word_t rand_point();
    point_word_t w;
    w.px = rand_coord(); w.py = rand_coord(); w.pz = rand_coord();
    w.ox = rand_coord(); w.oy = rand_coord(); w.oz = rand_coord();
    w.roll = rand_angle(); w.pitch = rand_angle(); w.yaw = rand_angle();
    return w;
  endfunction

  function automatic table_row_t mk_row(longint px, longint py, longint pz,
                                        longint ox, longint oy, longint oz,
                                        int ro, int pi, int ya, bit known,
                                        longint ex, longint ey, longint ez);
    table_row_t t;
    t.w.px = CW'(px); t.w.py = CW'(py); t.w.pz = CW'(pz);
    t.w.ox = CW'(ox); t.w.oy = CW'(oy); t.w.oz = CW'(oz);
    t.w.roll = 20'(ro); t.w.pitch = 20'(pi); t.w.yaw = 20'(ya);
    t.known = known;
    t.r.x = CW'(ex); t.r.y = CW'(ey); t.r.z = CW'(ez);
    return t;
  endfunction

  function automatic void add_row(table_row_t t);
    dir_rows.insert(dir_rows.size(), t);
  endfunction

  task automatic send_word(point_word_t w);
    in_point_x <= w.px; in_point_y <= w.py; in_point_z <= w.pz;
    in_position_x <= w.ox; in_position_y <= w.oy; in_position_z <= w.oz;
    in_roll_angle <= w.roll; in_pitch_angle <= w.pitch; in_yaw_angle <= w.yaw;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_body.insert(pending_body.size(), transform_point(w));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // receiver: stall pattern, switched off for some stretches
  always @(negedge clk) begin
    if (stall_free) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_body.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %0d %0d %0d", out_x, out_y, out_z);
      end else begin
        body_word_t e;
        e = pending_body.pop_front();
        words_checked++;
        if (e.x !== out_x || e.y !== out_y || e.z !== out_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     e.x, e.y, e.z, out_x, out_y, out_z);
        end
      end
    end
  end

  initial begin
    table_row_t t;
    int waited, burst;
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    in_point_x = 0; in_point_y = 0; in_point_z = 0;
    in_position_x = 0; in_position_y = 0; in_position_z = 0;
    in_roll_angle = 0; in_pitch_angle = 0; in_yaw_angle = 0;

    // zero offset gives an exact zero word, with zero, whole turn and half turn angles
    add_row(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    add_row(mk_row(5, 5, 5, 5, 5, 5, 360000, -360000, 180000, 1, 0, 0, 0));
    // offset overflow and saturation at both ends, then turns and folds checked by the predictor
    add_row(mk_row(mx, mx, mx, mn, mn, mn, 0, 0, 0, 1, mx, mn, mx));
    add_row(mk_row(mn, mn, mn, mx, mx, mx, 0, 0, 0, 1, mn, mx, mn));
    add_row(mk_row(1000, 2000, 3000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(1000, 2000, 3000, 0, 0, 0, 90000, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(1000, 2000, 3000, 0, 0, 0, 0, 90000, 0, 0, 0, 0, 0));
    add_row(mk_row(1000, 2000, 3000, 0, 0, 0, 0, 0, 90000, 0, 0, 0, 0));
    add_row(mk_row(1000, 2000, 3000, 0, 0, 0, -90000, -90000, -90000,
                   0, 0, 0, 0));
    add_row(mk_row(1000, 2000, 3000, 0, 0, 0, 180000, -180000, 180001,
                   0, 0, 0, 0));
    add_row(mk_row(-7, 11, 13, 1, 2, 3, 524287, -524288, 360001, 0, 0, 0, 0));
    add_row(mk_row(-7, 11, 13, 1, 2, 3, 90001, 89999, -270000, 0, 0, 0, 0));
    add_row(mk_row(mx, 0, mn, 0, mn, 0, 45000, 30000, 60000, 0, 0, 0, 0));
    add_row(mk_row(-1, -1, -1, 0, 0, 0, 1, -1, 1, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      t = dir_rows[i];
      send_word(t.w);
      if (t.known) begin
        void'(pending_body.pop_back());
        pending_body.insert(pending_body.size(), t.r);
      end
    end
    idle_gap(1);

    while (words_sent < dir_rows.size() + N_RANDOM) begin
      stall_free = ($urandom_range(0, 7) == 0);
      burst = $urandom_range(1, 40);
      repeat (burst) send_word(rand_point());
      if ($urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        while (pending_body.size() != 0) @(negedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        idle_gap($urandom_range(1, 6));
      end
    end
    idle_gap(1);

    waited = 0;
    while (pending_body.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(negedge clk);

    $display("covered %0d directed rows (extremes, turns, folds) and random bursts",
             dir_rows.size());
    $display("sent %0d words, checked %0d results, %0d mismatches",
             words_sent, words_checked, mismatches);
    if (mismatches == 0 && pending_body.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d results still outstanding", pending_body.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
